// ===== sv/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and table functions of the quaternion to Euler unit.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int ATAN_FRAC = 24;
    localparam int DATA_W    = 40;
    localparam int ANG_W     = 34;
    localparam int SQ_W      = 62;
    localparam int PROD_W    = 34;

    localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(64'sd1509949440);

    // one vector in flight through the cordic row, angle in Q24 degrees
    typedef struct packed {
        logic                     zf;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
    } t_vec;

    // payload carried along the cell row
    typedef struct packed {
        t_vec              roll;
        t_vec              yaw;
        t_vec              pitch;
        logic [SQ_W-1:0]   sq_n;
        logic [SQ_W-1:0]   sq_r;
        logic signed [31:0] s;
        logic              sat;
    } t_pipe;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic [63:0] t;
        t = (64'd961263669 + (64'd1 << (i - 1))) >> i;
        case (i)
            0:       return ANG_W'(64'sd754974720);
            1:       return ANG_W'(64'sd445687602);
            2:       return ANG_W'(64'sd235489089);
            3:       return ANG_W'(64'sd119537938);
            4:       return ANG_W'(64'sd60000934);
            5:       return ANG_W'(64'sd30029717);
            6:       return ANG_W'(64'sd15018523);
            7:       return ANG_W'(64'sd7509720);
            8:       return ANG_W'(64'sd3754917);
            9:       return ANG_W'(64'sd1877466);
            10:      return ANG_W'(64'sd938734);
            11:      return ANG_W'(64'sd469367);
            12:      return ANG_W'(64'sd234683);
            default: return ANG_W'(t);
        endcase
    endfunction

    // fold the left half plane onto the right one
    function automatic t_vec vec_prep(input logic signed [DATA_W-1:0] x,
                                      input logic signed [DATA_W-1:0] y);
        t_vec v;
        v.zf = (x == '0) && (y == '0);
        v.x  = x;
        v.y  = y;
        v.z  = '0;
        if (x[DATA_W-1]) begin
            if (!y[DATA_W-1]) begin
                v.x = y;
                v.y = -x;
                v.z = DEG90;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -DEG90;
            end
        end
        return v;
    endfunction

endpackage

// ===== sv/q2e_if.sv =====
// ----------------------------------------------------------------------------
// q2e_if
// Stream interfaces for quaternion beats in and angle beats out.
// ----------------------------------------------------------------------------
interface q2e_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [16:0] yaw_deg;
    logic               pitch_saturated;
    modport source (output valid, roll_deg, pitch_deg, yaw_deg, pitch_saturated,
                    input ready);
    modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, pitch_saturated,
                    output ready);
endinterface

// ===== sv/q2e_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One result bit of the pipelined integer square root.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  q2e_pkg::t_pipe i_d,
    output q2e_pkg::t_pipe o_q
);
    import q2e_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

    t_pipe           r_q;
    t_pipe           n_q;
    logic [SQ_W-1:0] w_trial;

    always_comb begin
        n_q     = i_d;
        w_trial = i_d.sq_r + BIT;
        if (i_d.sq_n >= w_trial) begin
            n_q.sq_n = i_d.sq_n - w_trial;
            n_q.sq_r = (i_d.sq_r >> 1) + BIT;
        end else begin
            n_q.sq_r = i_d.sq_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== sv/q2e_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring cordic step applied to the roll, yaw and pitch vectors.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  q2e_pkg::t_pipe i_d,
    output q2e_pkg::t_pipe o_q
);
    import q2e_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN = atan_entry(STAGE);

    t_pipe r_q;
    t_pipe n_q;

    function automatic t_vec rot(input t_vec v);
        t_vec r;
        r = v;
        if (!v.y[DATA_W-1]) begin
            r.x = v.x + (v.y >>> STAGE);
            r.y = v.y - (v.x >>> STAGE);
            r.z = v.z + ATAN;
        end else begin
            r.x = v.x - (v.y >>> STAGE);
            r.y = v.y + (v.x >>> STAGE);
            r.z = v.z - ATAN;
        end
        return r;
    endfunction

    always_comb begin
        n_q       = i_d;
        n_q.roll  = rot(i_d.roll);
        n_q.yaw   = rot(i_d.yaw);
        n_q.pitch = rot(i_d.pitch);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== sv/quat_to_euler_angles_unit.sv =====
// ----------------------------------------------------------------------------
// quat_to_euler_angles_unit
// Quaternion (Q30) to roll, pitch and yaw in fixed-point degrees.
// ----------------------------------------------------------------------------
// path: products, sums, fold, sqrt cells, pitch fold, cordic cells, output
// throughput: one beat per cycle, set by the row of cells (31 square root
//   cells, then CORDIC_STAGES cordic cells) that advance unless stalled
// a stalled output holds every full stage behind it; empty stages keep filling
// reset clears the valid bits only; no clearing pass
module quat_to_euler_angles_unit #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    q2e_in_if.sink           i_in,
    q2e_out_if.source        o_out
);
    import q2e_pkg::*;

    localparam int SQ_CELLS = 31;
    localparam int NPIPE    = SQ_CELLS + 2 + CORDIC_STAGES;
    localparam int NST      = NPIPE + 3;
    localparam int SH       = ATAN_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W:0] RND     = (ANG_W+1)'(1) <<< (SH - 1);
    localparam logic signed [ANG_W:0] LIM_180 = (ANG_W+1)'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W:0] LIM_90  = (ANG_W+1)'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [DATA_W-1:0] S_ONE = DATA_W'(64'sd1073741824);

    typedef struct packed {
        logic signed [PROD_W-1:0] ww, xx, yy, zz, wx, yz, wy, xz, xy, wz;
    } t_prod;

    typedef struct packed {
        logic signed [DATA_W-1:0] rx, ry, yx, yy;
        logic signed [31:0]       s;
        logic                     sat;
    } t_sum;

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_adv;
    t_prod          r_prod, n_prod;
    t_sum           r_sum, n_sum;
    t_pipe          w_pipe [NPIPE];
    t_pipe          n_pipe0, n_pprep;
    t_pipe          r_pipe0, r_pprep;
    logic signed [16:0] r_roll, r_yaw;
    logic signed [15:0] r_pitch;
    logic               r_sat;

    function automatic logic signed [PROD_W-1:0] mq30(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[63:30];
    endfunction

    function automatic logic signed [ANG_W:0] to_angle(input t_vec v,
                                                       input logic signed [ANG_W:0] lim);
        logic signed [ANG_W:0] r;
        r = (($signed({v.z[ANG_W-1], v.z}) + RND) >>> SH);
        if (v.zf) begin
            r = '0;
        end
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    // ready chain: a stage moves when it is empty or the next one moves
    always_comb begin
        w_adv[NST-1] = !r_v[NST-1] || o_out.ready;
        for (int j = NST - 2; j >= 0; j--) begin
            w_adv[j] = !r_v[j] || w_adv[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int j = 1; j < NST; j++) begin
                if (w_adv[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    assign i_in.ready = w_adv[0];

    // products
    always_comb begin
        n_prod.ww = mq30(i_in.quat_w, i_in.quat_w);
        n_prod.xx = mq30(i_in.quat_x, i_in.quat_x);
        n_prod.yy = mq30(i_in.quat_y, i_in.quat_y);
        n_prod.zz = mq30(i_in.quat_z, i_in.quat_z);
        n_prod.wx = mq30(i_in.quat_w, i_in.quat_x);
        n_prod.yz = mq30(i_in.quat_y, i_in.quat_z);
        n_prod.wy = mq30(i_in.quat_w, i_in.quat_y);
        n_prod.xz = mq30(i_in.quat_x, i_in.quat_z);
        n_prod.xy = mq30(i_in.quat_x, i_in.quat_y);
        n_prod.wz = mq30(i_in.quat_w, i_in.quat_z);
    end

    // sums, doubling and asin argument clamp
    always_comb begin
        logic signed [DATA_W-1:0] s40;
        s40 = (DATA_W'(r_prod.wy) - DATA_W'(r_prod.xz)) <<< 1;
        n_sum.rx = DATA_W'(r_prod.ww) - DATA_W'(r_prod.xx)
                 - DATA_W'(r_prod.yy) + DATA_W'(r_prod.zz);
        n_sum.ry = (DATA_W'(r_prod.wx) + DATA_W'(r_prod.yz)) <<< 1;
        n_sum.yx = DATA_W'(r_prod.ww) + DATA_W'(r_prod.xx)
                 - DATA_W'(r_prod.yy) - DATA_W'(r_prod.zz);
        n_sum.yy = (DATA_W'(r_prod.xy) + DATA_W'(r_prod.wz)) <<< 1;
        n_sum.sat = 1'b0;
        n_sum.s   = s40[31:0];
        if (s40 > S_ONE) begin
            n_sum.s   = S_ONE[31:0];
            n_sum.sat = 1'b1;
        end else if (s40 < -S_ONE) begin
            n_sum.s   = -S_ONE[31:0];
            n_sum.sat = 1'b1;
        end
    end

    // square of the argument and fold of roll and yaw vectors
    always_comb begin
        logic signed [63:0] ss;
        logic signed [63:0] rem;
        ss            = r_sum.s * r_sum.s;
        rem           = 64'sh1000_0000_0000_0000 - ss;
        n_pipe0       = '0;
        n_pipe0.roll  = vec_prep(r_sum.rx, r_sum.ry);
        n_pipe0.yaw   = vec_prep(r_sum.yx, r_sum.yy);
        n_pipe0.sq_n  = rem[SQ_W-1:0];
        n_pipe0.sq_r  = '0;
        n_pipe0.s     = r_sum.s;
        n_pipe0.sat   = r_sum.sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_prod <= n_prod;
        end
        if (w_adv[1]) begin
            r_sum <= n_sum;
        end
        if (w_adv[2]) begin
            r_pipe0 <= n_pipe0;
        end
    end

    assign w_pipe[0] = r_pipe0;

    genvar gk;
    generate
        for (gk = 0; gk < SQ_CELLS; gk++) begin : g_sqrt
            q2e_sqrt_cell #(.K(SQ_CELLS - 1 - gk)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv[3+gk]),
                .i_d   (w_pipe[gk]),
                .o_q   (w_pipe[gk+1])
            );
        end
    endgenerate

    // pitch vector: asin as atan2 of argument over the root
    always_comb begin
        n_pprep       = w_pipe[SQ_CELLS];
        n_pprep.pitch = vec_prep(DATA_W'($signed({1'b0, w_pipe[SQ_CELLS].sq_r[30:0]})),
                                 DATA_W'(w_pipe[SQ_CELLS].s));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3+SQ_CELLS]) begin
            r_pprep <= n_pprep;
        end
    end

    assign w_pipe[SQ_CELLS+1] = r_pprep;

    generate
        for (gk = 0; gk < CORDIC_STAGES; gk++) begin : g_cordic
            q2e_cordic_cell #(.STAGE(gk)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv[SQ_CELLS+4+gk]),
                .i_d   (w_pipe[SQ_CELLS+1+gk]),
                .o_q   (w_pipe[SQ_CELLS+2+gk])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        logic signed [ANG_W:0] a_roll, a_pitch, a_yaw;
        a_roll  = to_angle(w_pipe[NPIPE-1].roll, LIM_180);
        a_pitch = to_angle(w_pipe[NPIPE-1].pitch, LIM_90);
        a_yaw   = to_angle(w_pipe[NPIPE-1].yaw, LIM_180);
        if (w_adv[NST-1]) begin
            r_roll  <= a_roll[16:0];
            r_pitch <= a_pitch[15:0];
            r_yaw   <= a_yaw[16:0];
            r_sat   <= w_pipe[NPIPE-1].sat;
        end
    end

    assign o_out.valid           = r_v[NST-1];
    assign o_out.roll_deg        = r_roll;
    assign o_out.pitch_deg       = r_pitch;
    assign o_out.yaw_deg         = r_yaw;
    assign o_out.pitch_saturated = r_sat;

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NST-1] |-> i_in.ready)
        else $error("input not ready with empty output stage");

    a_sink_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("row stalled while sink ready");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2+SQ_CELLS] |-> (w_pipe[SQ_CELLS].sq_r <= (SQ_W'(1) << 30)))
        else $error("square root out of range");

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2+SQ_CELLS] |-> (w_pipe[SQ_CELLS].sq_n <= (w_pipe[SQ_CELLS].sq_r << 1)))
        else $error("square root remainder too large");

endmodule
